FILE: sv/hbfs_pkg.sv
package hbfs_pkg;

    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int MID_WORDS  = WORD_BITS;
    localparam int LEAF_WORDS = WORD_BITS * WORD_BITS;
    localparam int MID_AW     = $clog2(MID_WORDS);
    localparam int LEAF_AW    = $clog2(LEAF_WORDS);
    localparam int IDX_W      = LEAF_AW + BIT_W;
    localparam int CNT_W      = IDX_W + 1;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(LEAF_WORDS * WORD_BITS);

    typedef enum logic [1:0] {
        MODE_SET   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_FIND  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        LVL_TOP  = 2'd0,
        LVL_MID  = 2'd1,
        LVL_LEAF = 2'd2
    } t_lvl;

endpackage

FILE: sv/hbfs_ram.sv
module hbfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/hierarchical_bitmap_find_set.sv
// channel   | dir | tdata (low bit up)      | tuser       | notes
// s_axis    | in  | index[17:0], pad to 24  | mode[1:0]   | set / clear / find request
// m_axis    | out | result_index[18:0], pad | ok          | one result per request
// cfg       | in  | element_count[18:0]     | -           | write enable, no read-back
//
// after reset a clearing pass zeroes the leaf and middle memories, no requests taken
// set / clear: read and update the leaf word, climbing a level while the word was or becomes
// empty (refused index or unused mode skips to the result), find: up to 5 words visited
// one request at a time; the output register lets the next request start while a result waits
// a finished request holds in its last state while the output register is still occupied
module hierarchical_bitmap_find_set (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [18:0] i_cfg_wr_data,   // element_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // index[17:0], zeros above
    input  logic [1:0]  s_axis_tuser,    // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // result_index[18:0], zeros above
    output logic        m_axis_tuser     // ok
);

    localparam int WB = hbfs_pkg::WORD_BITS;
    localparam int BW = hbfs_pkg::BIT_W;
    localparam int MA = hbfs_pkg::MID_AW;
    localparam int LA = hbfs_pkg::LEAF_AW;
    localparam int IW = hbfs_pkg::IDX_W;
    localparam int CW = hbfs_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_EV,
        ST_DONE
    } t_state;

    t_state           r_state;
    hbfs_pkg::t_mode  r_mode;
    hbfs_pkg::t_lvl   r_lvl;
    logic [LA-1:0]    r_off;
    logic [BW:0]      r_bit;
    logic [WB-1:0]    r_top;
    logic [CW-1:0]    r_elem_count;
    logic [LA-1:0]    r_clr_cnt;
    logic [CW-1:0]    r_res;
    logic             r_res_ok;
    logic             r_out_valid;
    logic [CW-1:0]    r_out_data;
    logic             r_out_ok;

    logic [WB-1:0]    mid_rdata;
    logic [WB-1:0]    leaf_rdata;
    logic             mid_we;
    logic             leaf_we;
    logic [WB-1:0]    wr_word;
    logic [MA-1:0]    mid_addr;
    logic [LA-1:0]    leaf_addr;

    logic [WB-1:0]    cur_word;
    logic [WB-1:0]    bit_mask;
    logic [WB-1:0]    new_word;
    logic [WB-1:0]    scan_word;
    logic             scan_hit;
    logic [BW-1:0]    scan_pos;
    logic             upd_climb;

    hbfs_pkg::t_mode  in_mode;
    logic [IW-1:0]    in_idx;
    logic             in_valid;
    logic             out_free;

    assign in_mode  = hbfs_pkg::t_mode'(s_axis_tuser);
    assign in_idx   = s_axis_tdata[IW-1:0];
    assign in_valid = {1'b0, in_idx} < r_elem_count;
    assign out_free = !r_out_valid || m_axis_tready;

    // word of the current level, top level lives in flip-flops
    always_comb begin
        case (r_lvl)
            hbfs_pkg::LVL_TOP:  cur_word = r_top;
            hbfs_pkg::LVL_MID:  cur_word = mid_rdata;
            hbfs_pkg::LVL_LEAF: cur_word = leaf_rdata;
            default:            cur_word = r_top;
        endcase
    end

    assign bit_mask  = {{(WB-1){1'b0}}, 1'b1} << r_bit[BW-1:0];
    assign new_word  = (r_mode == hbfs_pkg::MODE_SET) ? (cur_word | bit_mask)
                                                      : (cur_word & ~bit_mask);
    assign upd_climb = (r_mode == hbfs_pkg::MODE_SET) ? (cur_word == '0) : (new_word == '0);

    // shared scan unit: first set bit at or above r_bit, none once r_bit reaches the word width
    assign scan_word = cur_word & ({WB{1'b1}} << r_bit);

    always_comb begin
        scan_hit = 1'b0;
        scan_pos = '0;
        for (int k = WB - 1; k >= 0; k--) begin
            if (scan_word[k]) begin
                scan_hit = 1'b1;
                scan_pos = BW'(k);
            end
        end
    end

    always_comb begin
        mid_we    = 1'b0;
        leaf_we   = 1'b0;
        wr_word   = new_word;
        mid_addr  = r_off[MA-1:0];
        leaf_addr = r_off;
        if (r_state == ST_CLR) begin
            mid_we    = 1'b1;
            leaf_we   = 1'b1;
            wr_word   = '0;
            mid_addr  = r_clr_cnt[MA-1:0];
            leaf_addr = r_clr_cnt;
        end else if (r_state == ST_EV && r_mode != hbfs_pkg::MODE_FIND) begin
            mid_we  = (r_lvl == hbfs_pkg::LVL_MID);
            leaf_we = (r_lvl == hbfs_pkg::LVL_LEAF);
        end
    end

    hbfs_ram #(.WIDTH(WB), .DEPTH(hbfs_pkg::MID_WORDS)) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (mid_we),
        .i_waddr (mid_addr),
        .i_wdata (wr_word),
        .i_raddr (r_off[MA-1:0]),
        .o_rdata (mid_rdata)
    );

    hbfs_ram #(.WIDTH(WB), .DEPTH(hbfs_pkg::LEAF_WORDS)) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (leaf_we),
        .i_waddr (leaf_addr),
        .i_wdata (wr_word),
        .i_raddr (r_off),
        .o_rdata (leaf_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLR;
            r_clr_cnt    <= '0;
            r_top        <= '0;
            r_elem_count <= hbfs_pkg::COUNT_RESET;
            r_out_valid  <= 1'b0;
            r_mode       <= hbfs_pkg::MODE_NONE;
            r_lvl        <= hbfs_pkg::LVL_TOP;
        end else begin
            if (i_cfg_wr_en) begin
                r_elem_count <= i_cfg_wr_data;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_mode <= in_mode;
                        r_lvl  <= hbfs_pkg::LVL_LEAF;
                        r_off  <= in_idx[IW-1:BW];
                        r_bit  <= {1'b0, in_idx[BW-1:0]};
                        case (in_mode)
                            hbfs_pkg::MODE_SET, hbfs_pkg::MODE_CLEAR: begin
                                r_res    <= {1'b0, in_idx};
                                r_res_ok <= in_valid;
                                r_state  <= in_valid ? ST_RD : ST_DONE;
                            end
                            hbfs_pkg::MODE_FIND: begin
                                r_state <= ST_RD;
                            end
                            default: begin
                                r_res    <= '0;
                                r_res_ok <= 1'b0;
                                r_state  <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_RD: begin
                    r_state <= ST_EV;
                end
                ST_EV: begin
                    if (r_mode == hbfs_pkg::MODE_FIND) begin
                        if (scan_hit) begin
                            if (r_lvl == hbfs_pkg::LVL_LEAF) begin
                                r_res    <= {1'b0, r_off, scan_pos};
                                r_res_ok <= 1'b1;
                                r_state  <= ST_DONE;
                            end else begin
                                // descend into the set child
                                r_lvl   <= hbfs_pkg::t_lvl'(r_lvl + 2'd1);
                                r_off   <= LA'({r_off, scan_pos});
                                r_bit   <= '0;
                                r_state <= ST_RD;
                            end
                        end else if (r_lvl == hbfs_pkg::LVL_TOP) begin
                            r_res    <= r_elem_count;
                            r_res_ok <= 1'b0;
                            r_state  <= ST_DONE;
                        end else begin
                            // word exhausted: resume in the parent just past this word
                            r_lvl   <= hbfs_pkg::t_lvl'(r_lvl - 2'd1);
                            r_bit   <= {1'b0, r_off[BW-1:0]} + 1'b1;
                            r_off   <= r_off >> BW;
                            r_state <= ST_RD;
                        end
                    end else begin
                        if (r_lvl == hbfs_pkg::LVL_TOP) begin
                            r_top <= new_word;
                        end
                        if (upd_climb && r_lvl != hbfs_pkg::LVL_TOP) begin
                            r_lvl   <= hbfs_pkg::t_lvl'(r_lvl - 2'd1);
                            r_bit   <= {1'b0, r_off[BW-1:0]};
                            r_off   <= r_off >> BW;
                            r_state <= ST_RD;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_data  <= r_res;
                        r_out_ok    <= r_res_ok;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(24-CW){1'b0}}, r_out_data};
    assign m_axis_tuser  = r_out_ok;

`ifndef SYNTHESIS
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in progress");

    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lvl == hbfs_pkg::LVL_TOP || r_lvl == hbfs_pkg::LVL_MID
         || r_lvl == hbfs_pkg::LVL_LEAF))
        else $error("level register out of range");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (leaf_we || mid_we) |-> (r_state == ST_CLR || r_state == ST_EV))
        else $error("memory write outside clear pass or update");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !m_axis_tready) |=> (r_state == ST_DONE))
        else $error("result dropped while output register busy");
`endif

endmodule
